// ----- design/mbpc_pkg.sv -----
// Shared types, codes and reset constants of the key matrix press classifier.
// No dependencies; every other design file refers to this package by scope.
package mbpc_pkg;

  // Default matrix geometry.
  localparam int unsigned ROWS_DEF    = 2;
  localparam int unsigned COLUMNS_DEF = 5;

  // Reset values of the configuration registers.
  localparam logic [15:0] BOUNCE_RST     = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [15:0] STUCK_RST      = 16'd10000;
  localparam logic [15:0] LOCKOUT_RST    = 16'd400;

  // Configuration register indexes (byte address divided by four).
  localparam logic [1:0] REG_BOUNCE     = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_STUCK      = 2'd2;
  localparam logic [1:0] REG_LOCKOUT    = 2'd3;

  // Event kinds; codes with the upper bit set are lockout checks.
  localparam logic [1:0] OP_PRESS = 2'd0;

  // Driven row codes.
  localparam logic [1:0] ROW_ZERO = 2'd1;
  localparam logic [1:0] ROW_ONE  = 2'd2;

  typedef enum logic [3:0] {
    OC_NO_ROW        = 4'd0,
    OC_NO_BUTTON     = 4'd1,
    OC_LOCKED        = 4'd2,
    OC_PRESS_STARTED = 4'd3,
    OC_BOUNCE        = 4'd4,
    OC_STUCK         = 4'd5,
    OC_SHORT         = 4'd6,
    OC_LONG          = 4'd7,
    OC_CHECK_DONE    = 4'd8
  } outcome_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  row_driven;
    logic [2:0]  key_column;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [3:0] outcome;
    logic [3:0] button_index;
    logic       press_active;
  } out_t;

  typedef struct packed {
    logic [15:0] bounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] stuck_ms;
    logic [15:0] lockout_ms;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic decode;
    logic look;
    logic classify;
    logic walk;
    logic load_out;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_check;
    logic is_invalid;
    logic walk_last;
  } sts_t;

endpackage

// ----- design/mbpc_regs.sv -----
// Configuration register file of the press classifier, APB-style write and read.
// Depends on mbpc_pkg for register indexes, reset values and cfg_t.
module mbpc_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output mbpc_pkg::cfg_t      cfg_o
);

  mbpc_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write the addressed register on the access cycle.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        mbpc_pkg::REG_BOUNCE:     cfg_d.bounce_ms     = pwdata[15:0];
        mbpc_pkg::REG_LONG_PRESS: cfg_d.long_press_ms = pwdata[15:0];
        mbpc_pkg::REG_STUCK:      cfg_d.stuck_ms      = pwdata[15:0];
        mbpc_pkg::REG_LOCKOUT:    cfg_d.lockout_ms    = pwdata[15:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bounce_ms     <= mbpc_pkg::BOUNCE_RST;
      cfg_q.long_press_ms <= mbpc_pkg::LONG_PRESS_RST;
      cfg_q.stuck_ms      <= mbpc_pkg::STUCK_RST;
      cfg_q.lockout_ms    <= mbpc_pkg::LOCKOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Return the addressed register, zero extended.
  always_comb begin
    unique case (paddr[3:2])
      mbpc_pkg::REG_BOUNCE:     prdata = {16'd0, cfg_q.bounce_ms};
      mbpc_pkg::REG_LONG_PRESS: prdata = {16'd0, cfg_q.long_press_ms};
      mbpc_pkg::REG_STUCK:      prdata = {16'd0, cfg_q.stuck_ms};
      mbpc_pkg::REG_LOCKOUT:    prdata = {16'd0, cfg_q.lockout_ms};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/mbpc_ctrl.sv -----
// Sequencing state machine of the press classifier: input and output handshakes.
// Depends on mbpc_pkg for the command and status structs.
module mbpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  mbpc_pkg::sts_t sts_i,
  output mbpc_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_LOOK     = 6'b000100,
    S_CLASSIFY = 6'b001000,
    S_WALK     = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The output register can take a result when empty or emptying.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        priority if (sts_i.is_check) begin
          state_d = S_WALK;
        end else if (sts_i.is_invalid) begin
          state_d = S_DONE;
        end else begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_CLASSIFY;
      end
      S_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        state_d        = S_DONE;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Set valid on load, drop it once the transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/mbpc_datapath.sv -----
// Datapath of the press classifier: per-button timestamps, lockout deadlines,
// hold time measurement and classification. Depends on mbpc_pkg.
module mbpc_datapath #(
  parameter int unsigned ROWS    = mbpc_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = mbpc_pkg::COLUMNS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mbpc_pkg::in_t  in_data_i,
  input  mbpc_pkg::cfg_t cfg_i,
  input  mbpc_pkg::cmd_t cmd_i,
  output mbpc_pkg::sts_t sts_o,
  output mbpc_pkg::out_t out_data_o
);

  localparam int unsigned NB    = ROWS * COLUMNS;
  localparam int unsigned IDX_W = (NB > 1) ? $clog2(NB) : 1;

  mbpc_pkg::in_t      in_q;
  mbpc_pkg::outcome_e outcome_q;
  mbpc_pkg::out_t     out_q;
  logic [IDX_W-1:0]   idx_q, cnt_q;
  logic [31:0]        held_q;
  logic               locked_q;
  logic               pip_q;
  logic [31:0]        start_q [NB];
  logic [31:0]        until_q [NB];

  logic             row_ok, col_ok, row_bit;
  logic [7:0]       idx_wide;
  logic [31:0]      held_now;
  logic [31:0]      bounce_w, long_w, stuck_w;

  // Decode the addressed button from the captured event.
  assign row_bit  = (in_q.row_driven == mbpc_pkg::ROW_ONE);
  assign row_ok   = (in_q.row_driven == mbpc_pkg::ROW_ZERO) ||
                    ((in_q.row_driven == mbpc_pkg::ROW_ONE) && (ROWS > 1));
  assign col_ok   = (5'(in_q.key_column) < 5'(COLUMNS));
  assign idx_wide = (row_bit ? 8'(COLUMNS) : 8'd0) + {5'd0, in_q.key_column};

  assign sts_o.is_check   = in_q.operation[1];
  assign sts_o.is_invalid = !(row_ok && col_ok);
  assign sts_o.walk_last  = (cnt_q == IDX_W'(NB - 1));

  assign held_now = held_q;
  assign bounce_w = {16'd0, cfg_i.bounce_ms};
  assign long_w   = {16'd0, cfg_i.long_press_ms};
  assign stuck_w  = {16'd0, cfg_i.stuck_ms};

  // Capture, decode and look up the event's button, classify it and load the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.decode) begin
      cnt_q <= '0;
      priority if (sts_o.is_check) begin
        outcome_q <= mbpc_pkg::OC_CHECK_DONE;
        idx_q     <= '0;
      end else if (!row_ok) begin
        outcome_q <= mbpc_pkg::OC_NO_ROW;
        idx_q     <= '0;
      end else if (!col_ok) begin
        outcome_q <= mbpc_pkg::OC_NO_BUTTON;
        idx_q     <= '0;
      end else begin
        outcome_q <= mbpc_pkg::OC_CHECK_DONE;
        idx_q     <= idx_wide[IDX_W-1:0];
      end
    end
    if (cmd_i.look) begin
      locked_q <= (until_q[idx_q] > in_q.now_ms);
      held_q   <= in_q.now_ms - start_q[idx_q];
    end
    if (cmd_i.walk) begin
      cnt_q <= cnt_q + IDX_W'(1);
    end
    if (cmd_i.classify) begin
      priority if (locked_q) begin
        outcome_q <= mbpc_pkg::OC_LOCKED;
      end else if (in_q.operation == mbpc_pkg::OP_PRESS) begin
        outcome_q <= mbpc_pkg::OC_PRESS_STARTED;
      end else if (held_now <= bounce_w) begin
        outcome_q <= mbpc_pkg::OC_BOUNCE;
      end else if (held_now >= stuck_w) begin
        outcome_q <= mbpc_pkg::OC_STUCK;
      end else if (held_now > long_w) begin
        outcome_q <= mbpc_pkg::OC_LONG;
      end else begin
        outcome_q <= mbpc_pkg::OC_SHORT;
      end
    end
    if (cmd_i.load_out) begin
      out_q.outcome      <= outcome_q;
      out_q.button_index <= 4'(idx_q);
      out_q.press_active <= pip_q;
    end
  end

  // Update button state and the press flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pip_q <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        start_q[i] <= '0;
        until_q[i] <= '0;
      end
    end else begin
      if (cmd_i.walk && (until_q[cnt_q] > in_q.now_ms)) begin
        pip_q <= 1'b0;
      end
      if (cmd_i.classify) begin
        priority if (locked_q) begin
          pip_q <= 1'b0;
        end else if (in_q.operation == mbpc_pkg::OP_PRESS) begin
          pip_q          <= 1'b1;
          start_q[idx_q] <= in_q.now_ms;
        end else if (held_now > bounce_w) begin
          pip_q          <= 1'b0;
          start_q[idx_q] <= '0;
          until_q[idx_q] <= in_q.now_ms + {16'd0, cfg_i.lockout_ms};
        end
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- design/matrix_button_press_classifier_top.sv -----
// Top level of the key matrix press classifier: registers, controller, datapath.
// Depends on mbpc_pkg, mbpc_regs, mbpc_ctrl and mbpc_datapath.

// Classifies press, release and lockout check events on a ROWS by COLUMNS key
// matrix and gives one result per event. The block takes one event at a time:
// a press or release with no valid row or column goes through decode and
// output load, a valid press or release through decode, state lookup,
// classification and output load, and a lockout check through decode, a scan
// of the lockout deadlines one button per cycle, and output load. The next
// event is taken in the cycle after the result is loaded; a loaded result
// waits in the output register without holding up the next event. Button
// state is cleared at reset.
module matrix_button_press_classifier_top #(
  parameter int unsigned ROWS    = mbpc_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = mbpc_pkg::COLUMNS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mbpc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mbpc_pkg::out_t out_data_o
);

  mbpc_pkg::cfg_t cfg;
  mbpc_pkg::cmd_t cmd;
  mbpc_pkg::sts_t sts;

  mbpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mbpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mbpc_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
